/* sv/fmop_pkg.sv */
// Package for the two-operator FM voice: sequencer operation codes,
// controller state type, command struct and the exp2 mantissa table.
// No dependencies.
package fmop_pkg;

  localparam int unsigned PhaseBitsDef     = 24;
  localparam int unsigned SineTableBitsDef = 10;
  localparam int unsigned SampleBitsDef    = 16;

  // Quarter-wave quintic coefficients, Q15
  localparam logic [16:0] SIN_A = 17'd51472;
  localparam logic [16:0] SIN_B = 17'd21024;
  localparam logic [16:0] SIN_C = 17'd2320;

  // Configuration register indexes
  localparam logic [2:0] REG_BASE_INC  = 3'd0;
  localparam logic [2:0] REG_MOD_RATIO = 3'd1;
  localparam logic [2:0] REG_MOD_INDEX = 3'd2;
  localparam logic [2:0] REG_TRIM_L    = 3'd3;
  localparam logic [2:0] REG_TRIM_R    = 3'd4;
  localparam logic [2:0] REG_MODE      = 3'd5;

  // Mode bits
  localparam int unsigned ModeStereo = 2;
  localparam int unsigned ModePitch  = 1;
  localparam int unsigned ModeRange  = 0;

  // One multiply per operation, issued in this order
  typedef enum logic [3:0] {
    OP_MANT    = 4'd0,
    OP_STEP    = 4'd1,
    OP_SQ_C    = 4'd2,
    OP_CX2_C   = 4'd3,
    OP_TX2_C   = 4'd4,
    OP_XT_C    = 4'd5,
    OP_SQ_M    = 4'd6,
    OP_CX2_M   = 4'd7,
    OP_TX2_M   = 4'd8,
    OP_XT_M    = 4'd9,
    OP_DEPTH   = 4'd10,
    OP_MODSTEP = 4'd11,
    OP_CSTEP   = 4'd12,
    OP_LV      = 4'd13,
    OP_LEFT    = 4'd14,
    OP_RIGHT   = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_RUN   = 2'd1,
    ST_WRITE = 2'd2
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture the request
    logic exec;   // run op this cycle
    op_e  op;
    logic write;  // move results to the output register
  } dp_cmd_t;

  // 2^(k/16) in Q16
  function automatic logic [17:0] exp2_tab(input logic [4:0] k);
    logic [17:0] r;
    unique case (k)
      5'd0:  r = 18'd65536;
      5'd1:  r = 18'd68438;
      5'd2:  r = 18'd71468;
      5'd3:  r = 18'd74632;
      5'd4:  r = 18'd77936;
      5'd5:  r = 18'd81386;
      5'd6:  r = 18'd84990;
      5'd7:  r = 18'd88752;
      5'd8:  r = 18'd92682;
      5'd9:  r = 18'd96785;
      5'd10: r = 18'd101070;
      5'd11: r = 18'd105545;
      5'd12: r = 18'd110218;
      5'd13: r = 18'd115097;
      5'd14: r = 18'd120193;
      5'd15: r = 18'd125515;
      default: r = 18'd131072;
    endcase
    return r;
  endfunction

endpackage

/* sv/fmop_ctrl.sv */
// Controller for the FM voice: request handshake, operation sequencer
// and output valid. Depends on fmop_pkg.
module fmop_ctrl
  import fmop_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      ST_IDLE: begin
        op_d = OP_MANT;
        if (in_valid_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        op_d = op_e'(op_q + 4'd1);
        if (op_q == OP_RIGHT) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o.load  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.exec  = (state_q == ST_RUN);
    cmd_o.op    = op_q;
    cmd_o.write = (state_q == ST_WRITE) && out_free;
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_d = out_valid_q;
    if (cmd_o.write) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_MANT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* sv/fmop_dp.sv */
// Datapath for the FM voice: config registers, phases, one shared signed
// multiplier and the result registers. Depends on fmop_pkg.
module fmop_dp
  import fmop_pkg::*;
#(
  parameter int unsigned PHASE_BITS      = PhaseBitsDef,
  parameter int unsigned SINE_TABLE_BITS = SineTableBitsDef,
  parameter int unsigned SAMPLE_BITS     = SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dp_cmd_t                       cmd_i,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [23:0]                   cfg_data_i,
  input  logic [15:0]                   level_env_i,
  input  logic signed [15:0]            pitch_env_i,
  input  logic signed [15:0]            range_env_i,
  input  logic                          level_done_i,
  input  logic signed [SAMPLE_BITS-1:0] mix_left_in_i,
  input  logic signed [SAMPLE_BITS-1:0] mix_right_in_i,
  output logic signed [SAMPLE_BITS-1:0] mix_left_out_o,
  output logic signed [SAMPLE_BITS-1:0] mix_right_out_o,
  output logic                          voice_finished_o
);

  localparam int unsigned PW      = 52;
  localparam int unsigned OutSh   = 46 - SAMPLE_BITS;
  localparam int unsigned XShift  = 15 - (SINE_TABLE_BITS - 2);
  localparam logic signed [PW-1:0] SatHi = PW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [PW-1:0] SatLo = -SatHi - PW'(1);

  // Config registers
  logic [23:0]        base_q;
  logic [15:0]        ratio_q;
  logic signed [15:0] index_q, trim_l_q, trim_r_q;
  logic [2:0]         mode_q;

  // Request and state
  logic [15:0]                   level_q, pe_q;
  logic signed [15:0]            range_q;
  logic signed [SAMPLE_BITS-1:0] mixl_q, mixr_q;
  logic                          done_q;
  logic [PHASE_BITS-1:0]         car_q, mod_q;

  // Intermediates
  logic [31:0]         step_q;
  logic [16:0]         mant_q;
  logic [15:0]         x_q, x2_q;
  logic [16:0]         t_q;
  logic [1:0]          quad_q;
  logic signed [16:0]  sc_q, sm_q, m_q;
  logic signed [33:0]  lv_q;
  logic signed [SAMPLE_BITS-1:0] resl_q, resr_q;
  logic signed [SAMPLE_BITS-1:0] outl_q, outr_q;
  logic                          fin_q;

  // Multiplier operands and product
  logic signed [33:0]   a_s;
  logic signed [17:0]   b_s;
  logic signed [PW-1:0] prod;

  // Sine front end
  logic [PHASE_BITS-1:0]      ph;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [1:0]                 quad;
  logic [15:0]                x_raw, x;
  logic [16:0]                y;
  logic signed [16:0]         y_s;

  // Exp2 pieces
  logic [3:0]  oct8, kk;
  logic [7:0]  f8;
  logic [17:0] diff;
  logic [4:0]  shamt;
  logic signed [15:0] depth;
  logic signed [PW-1:0] sum_l, sum_r;

  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    if (v > SatHi) r = SatHi;
    else if (v < SatLo) r = SatLo;
    else r = v;
    return SAMPLE_BITS'(r);
  endfunction

  assign oct8  = pe_q[15:12];
  assign kk    = pe_q[11:8];
  assign f8    = pe_q[7:0];
  assign diff  = exp2_tab({1'b0, kk} + 5'd1) - exp2_tab({1'b0, kk});
  assign shamt = 5'd24 - {1'b0, oct8};
  assign depth = mode_q[ModeRange] ? range_q : index_q;

  // Angle from the top phase bits, folded into one quarter wave
  always_comb begin
    ph    = (cmd_i.op == OP_SQ_C) ? car_q : mod_q;
    idx   = ph[PHASE_BITS-1 -: SINE_TABLE_BITS];
    quad  = idx[SINE_TABLE_BITS-1 -: 2];
    x_raw = 16'(idx[SINE_TABLE_BITS-3:0]) << XShift;
    x     = quad[0] ? (16'd32768 - x_raw) : x_raw;
    y     = prod[31:15];
    if (y > 17'd32767) y = 17'd32767;
    y_s   = quad_q[1] ? -$signed(y) : $signed(y);
  end

  // Select multiplier operands
  always_comb begin
    unique case (cmd_i.op)
      OP_MANT: begin
        a_s = 34'(diff);
        b_s = 18'(f8);
      end
      OP_STEP: begin
        a_s = 34'(base_q);
        b_s = 18'(mant_q);
      end
      OP_SQ_C, OP_SQ_M: begin
        a_s = 34'(x);
        b_s = 18'(x);
      end
      OP_CX2_C, OP_CX2_M: begin
        a_s = 34'(SIN_C);
        b_s = 18'(x2_q);
      end
      OP_TX2_C, OP_TX2_M: begin
        a_s = 34'(t_q);
        b_s = 18'(x2_q);
      end
      OP_XT_C, OP_XT_M: begin
        a_s = 34'(x_q);
        b_s = 18'(t_q);
      end
      OP_DEPTH: begin
        a_s = 34'(sm_q);
        b_s = 18'(depth);
      end
      OP_MODSTEP: begin
        a_s = 34'(step_q);
        b_s = 18'(ratio_q);
      end
      OP_CSTEP: begin
        a_s = 34'(step_q);
        b_s = 18'(m_q);
      end
      OP_LV: begin
        a_s = 34'(sc_q);
        b_s = 18'(level_q);
      end
      OP_LEFT: begin
        a_s = lv_q;
        b_s = 18'(trim_l_q);
      end
      OP_RIGHT: begin
        a_s = lv_q;
        b_s = 18'(trim_r_q);
      end
      default: begin
        a_s = '0;
        b_s = '0;
      end
    endcase
  end

  assign prod  = a_s * b_s;
  assign sum_l = PW'(mixl_q) + (prod >>> OutSh);
  assign sum_r = PW'(mixr_q) + (prod >>> OutSh);

  // Config writes, phases and finish flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      ratio_q  <= 16'd256;
      index_q  <= '0;
      trim_l_q <= 16'sd16384;
      trim_r_q <= 16'sd16384;
      mode_q   <= '0;
      car_q    <= '0;
      mod_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_BASE_INC:  base_q   <= cfg_data_i;
          REG_MOD_RATIO: ratio_q  <= cfg_data_i[15:0];
          REG_MOD_INDEX: index_q  <= cfg_data_i[15:0];
          REG_TRIM_L:    trim_l_q <= cfg_data_i[15:0];
          REG_TRIM_R:    trim_r_q <= cfg_data_i[15:0];
          REG_MODE:      mode_q   <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (cmd_i.load && level_done_i) done_q <= 1'b1;
      if (cmd_i.exec && cmd_i.op == OP_MODSTEP) begin
        mod_q <= mod_q + PHASE_BITS'(prod >>> 8);
      end
      if (cmd_i.exec && cmd_i.op == OP_CSTEP) begin
        car_q <= car_q + PHASE_BITS'(step_q) + PHASE_BITS'(prod >>> 12);
      end
    end
  end

  // Capture the request and hold intermediates
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      level_q <= level_env_i;
      pe_q    <= {~pitch_env_i[15], pitch_env_i[14:0]};
      range_q <= range_env_i;
      mixl_q  <= mix_left_in_i;
      mixr_q  <= mix_right_in_i;
    end
    if (cmd_i.exec) begin
      unique case (cmd_i.op)
        OP_MANT: mant_q <= 17'(exp2_tab({1'b0, kk})) + prod[24:8];
        OP_STEP: begin
          if (mode_q[ModePitch]) step_q <= 32'(prod[40:0] >> shamt);
          else step_q <= 32'(base_q);
        end
        OP_SQ_C, OP_SQ_M: begin
          x_q    <= x;
          quad_q <= quad;
          x2_q   <= prod[30:15];
        end
        OP_CX2_C, OP_CX2_M: t_q <= SIN_B - prod[31:15];
        OP_TX2_C, OP_TX2_M: t_q <= SIN_A - prod[31:15];
        OP_XT_C:  sc_q <= y_s;
        OP_XT_M:  sm_q <= y_s;
        OP_DEPTH: m_q  <= 17'(prod >>> 15);
        OP_LV:    lv_q <= 34'(prod);
        OP_LEFT:  resl_q <= sat(sum_l);
        OP_RIGHT: resr_q <= mode_q[ModeStereo] ? sat(sum_r) : mixr_q;
        default: ;
      endcase
    end
    if (cmd_i.write) begin
      outl_q <= resl_q;
      outr_q <= resr_q;
      fin_q  <= done_q;
    end
  end

  assign mix_left_out_o   = outl_q;
  assign mix_right_out_o  = outr_q;
  assign voice_finished_o = fin_q;

endmodule

/* sv/fm_operator_pair_voice_top.sv */
// Top level of the two-operator FM voice: controller plus datapath.
// Depends on fmop_pkg, fmop_ctrl and fmop_dp.
//
// One audio frame per request. A frame is accepted only while the block is idle. The
// frame is captured at the accepting edge. It then passes through the single shared
// 34x18 multiplier, one multiply per step (exp2 mantissa, step, two four-multiply
// sines, depth, two phase steps, level, two channel gains), then into the output
// register once that register is free. The block is idle again in the cycle after that
// write, and only then takes a new frame. The output register lets the next frame start
// while the previous result waits to be taken. A second finished frame holds until that
// register frees up. Configuration must be written only while idle; the block itself
// does not enforce this.
module fm_operator_pair_voice_top
  import fmop_pkg::*;
#(
  parameter int unsigned PHASE_BITS      = PhaseBitsDef,
  parameter int unsigned SINE_TABLE_BITS = SineTableBitsDef,
  parameter int unsigned SAMPLE_BITS     = SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [23:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [15:0]                   level_env_i,
  input  logic signed [15:0]            pitch_env_i,
  input  logic signed [15:0]            range_env_i,
  input  logic                          level_done_i,
  input  logic signed [SAMPLE_BITS-1:0] mix_left_in_i,
  input  logic signed [SAMPLE_BITS-1:0] mix_right_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] mix_left_out_o,
  output logic signed [SAMPLE_BITS-1:0] mix_right_out_o,
  output logic                          voice_finished_o
);

  dp_cmd_t cmd;

  fmop_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  fmop_dp #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .level_env_i      (level_env_i),
    .pitch_env_i      (pitch_env_i),
    .range_env_i      (range_env_i),
    .level_done_i     (level_done_i),
    .mix_left_in_i    (mix_left_in_i),
    .mix_right_in_i   (mix_right_in_i),
    .mix_left_out_o   (mix_left_out_o),
    .mix_right_out_o  (mix_right_out_o),
    .voice_finished_o (voice_finished_o)
  );

endmodule

/* sv/fmop_checker.sv */
// Port-level checker for the FM voice, bound to the top level.
// Depends on fm_operator_pair_voice_top.
module fmop_checker #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [SAMPLE_BITS-1:0] mix_left_out_o,
  input logic                   voice_finished_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(mix_left_out_o))
    else $error("stalled result changed");

  // A taken request keeps the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");

  // Finished stays set once shown
  a_fin_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && voice_finished_o |=> !out_valid_o || voice_finished_o)
    else $error("voice_finished cleared");

endmodule

bind fm_operator_pair_voice_top fmop_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_fmop_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .mix_left_out_o   (mix_left_out_o),
  .voice_finished_o (voice_finished_o)
);

/* tb/sv/fm_operator_pair_voice_top_tb.sv */
// Testbench for fm_operator_pair_voice_top: directed and random frames through the
// valid/stall handshake, checked against a fixed-point FM voice predictor in a
// scoreboard class. Depends on fmop_pkg and the voice RTL.
`timescale 1ns / 1ps

module fm_operator_pair_voice_top_tb;
  import fmop_pkg::*;

  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    logic        fin;
  } frame_out_t;

  // Predicts the mixed output of each frame and holds the pending results
  class voice_scoreboard;
    logic [23:0] base_inc;
    logic [15:0] ratio;
    longint      index_q, trim_l, trim_r;
    logic [2:0]  mode;
    logic [23:0] car_ph, mod_ph;
    bit          done;
    frame_out_t  pending[$];
    int          mismatches;

    function new();
      base_inc = 0; ratio = 256; index_q = 0; trim_l = 16384; trim_r = 16384;
      mode = 0; car_ph = 0; mod_ph = 0; done = 0; mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
        REG_BASE_INC:  base_inc = val;
        REG_MOD_RATIO: ratio = val[15:0];
        REG_MOD_INDEX: index_q = longint'($signed(val[15:0]));
        REG_TRIM_L:    trim_l = longint'($signed(val[15:0]));
        REG_TRIM_R:    trim_r = longint'($signed(val[15:0]));
        REG_MODE:      mode = val[2:0];
        default: ;
      endcase
    endfunction

    function longint floor_sh(longint v, int s);
      return v >>> s;
    endfunction

    function longint sine_of(logic [23:0] ph);
      longint unsigned x, x2, t, y;
      logic [9:0] idx;
      idx = ph[23:14];
      x = longint'(idx[7:0]) << 7;
      if (idx[8]) x = 32768 - x;
      x2 = (x * x) >> 15;
      t = (2320 * x2) >> 15;
      t = 21024 - t;
      t = (t * x2) >> 15;
      t = 51472 - t;
      y = (x * t) >> 15;
      if (y > 32767) y = 32767;
      return idx[9] ? -longint'(y) : longint'(y);
    endfunction

    function longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function longint unsigned mant_of(int k);
      longint unsigned tab[17] = '{65536, 68438, 71468, 74632, 77936, 81386, 84990,
        88752, 92682, 96785, 101070, 105545, 110218, 115097, 120193, 125515, 131072};
      return tab[k];
    endfunction

    // Advance the voice by one frame and queue its result
    function void note_frame(logic [15:0] lvl, logic [15:0] pe, logic [15:0] rng,
                             logic ldone, logic [15:0] ml, logic [15:0] mr);
      longint unsigned step, mant, frac;
      logic [15:0] peo;
      int k, oct;
      longint sc, sm, depth, m, cstep, lv;
      frame_out_t r;
      step = base_inc;
      if (mode[ModePitch]) begin
        peo = pe + 16'h8000;
        oct = peo[15:12];
        frac = peo[11:0];
        k = frac >> 8;
        mant = mant_of(k) + (((mant_of(k + 1) - mant_of(k)) * (frac & 255)) >> 8);
        step = (longint'(base_inc) * mant) >> (24 - oct);
      end
      sc = sine_of(car_ph);
      sm = sine_of(mod_ph);
      mod_ph = mod_ph + 24'((step * ratio) >> 8);
      depth = mode[ModeRange] ? longint'($signed(rng)) : index_q;
      m = floor_sh(sm * depth, 15);
      cstep = longint'(step) + floor_sh(longint'(step) * m, 12);
      car_ph = car_ph + 24'(cstep);
      lv = sc * longint'(lvl);
      r.left = 16'(clip16(longint'($signed(ml)) + floor_sh(lv * trim_l, 30)));
      if (mode[ModeStereo])
        r.right = 16'(clip16(longint'($signed(mr)) + floor_sh(lv * trim_r, 30)));
      else
        r.right = mr;
      if (ldone) done = 1;
      r.fin = done;
      pending.push_back(r);
    endfunction

    function void check_result(logic [15:0] l, logic [15:0] rr, logic f);
      frame_out_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result l=%h r=%h f=%b", l, rr, f);
        return;
      end
      e = pending.pop_front();
      if (e.left !== l || e.right !== rr || e.fin !== f) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp l=%h r=%h f=%b got l=%h r=%h f=%b",
                   e.left, e.right, e.fin, l, rr, f);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [23:0] cfg_data_i;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic [15:0] level_env_i;
  logic signed [15:0] pitch_env_i, range_env_i, mix_left_in_i, mix_right_in_i;
  logic level_done_i;
  logic signed [15:0] mix_left_out_o, mix_right_out_o;
  logic voice_finished_o;

  voice_scoreboard sb;
  bit rx_hold;     // long receiver hold-off request
  bit rx_calm;     // receiver never stalls while set

  fm_operator_pair_voice_top dut (.*);

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("fm_operator_pair_voice_top_tb: errors");
    $finish;
  end

  task automatic write_cfg(logic [2:0] idx, logic [23:0] val);
    @(negedge clk_i);
    cfg_we_i = 1; cfg_idx_i = idx; cfg_data_i = val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 0;
  endtask

  // Offer one request and hold it until accepted
  task automatic send_frame(logic [15:0] lvl, logic [15:0] pe, logic [15:0] rng,
                            logic ld, logic [15:0] ml, logic [15:0] mr, int gap);
    repeat (gap) @(negedge clk_i);
    @(negedge clk_i);
    in_valid_i = 1; level_env_i = lvl; pitch_env_i = pe; range_env_i = rng;
    level_done_i = ld; mix_left_in_i = ml; mix_right_in_i = mr;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    sb.note_frame(lvl, pe, rng, ld, ml, mr);
    @(negedge clk_i);
    in_valid_i = 0;
  endtask

  task automatic send_random(int n, bit calm);
    int gap;
    repeat (n) begin
      gap = calm ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9));
      send_frame($urandom, $urandom, $urandom, ($urandom_range(0, 40) == 0),
                 $urandom, $urandom, gap);
    end
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  task automatic random_config();
    write_cfg(REG_BASE_INC, $urandom_range(0, 3) == 0 ? 24'hFFFFFF : $urandom);
    write_cfg(REG_MOD_RATIO, $urandom);
    write_cfg(REG_MOD_INDEX, $urandom);
    write_cfg(REG_TRIM_L, $urandom);
    write_cfg(REG_TRIM_R, $urandom);
    write_cfg(REG_MODE, $urandom_range(0, 7));
    write_cfg(3'd6, $urandom);
    write_cfg(3'd7, $urandom);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int wait_n;
    out_stall_i = 1;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold) begin
        out_stall_i = 1;
        repeat (120) @(negedge clk_i);
        rx_hold = 0;
      end
      wait_n = rx_calm ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9));
      out_stall_i = (wait_n != 0);
      if (wait_n != 0) begin
        repeat (wait_n - 1) @(negedge clk_i);
        @(negedge clk_i);
        out_stall_i = 0;
      end
      forever begin
        @(posedge clk_i);
        if (out_valid_o && !out_stall_i) break;
      end
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(mix_left_out_o, mix_right_out_o, voice_finished_o);

  initial begin
    sb = new();
    rx_hold = 0; rx_calm = 0;
    cfg_we_i = 0; cfg_idx_i = REG_BASE_INC; cfg_data_i = 0;
    in_valid_i = 0; level_env_i = 0; pitch_env_i = 0; range_env_i = 0;
    level_done_i = 0; mix_left_in_i = 0; mix_right_in_i = 0;
    rst_ni = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Directed: reset settings, then extremes in mono and stereo with both envelopes
    send_frame(16'hFFFF, 0, 0, 0, 16'h7FFF, 16'h8000, 0);
    drain();
    write_cfg(REG_BASE_INC, 24'h123456);
    write_cfg(REG_MOD_RATIO, 16'hFFFF);
    write_cfg(REG_MOD_INDEX, 16'h7FFF);
    write_cfg(REG_TRIM_L, 16'h7FFF);
    write_cfg(REG_TRIM_R, 16'h8000);
    write_cfg(REG_MODE, 3'd7);
    send_frame(16'hFFFF, 16'h7FFF, 16'h7FFF, 0, 16'h7FFF, 16'h7FFF, 0);
    send_frame(16'hFFFF, 16'h8000, 16'h8000, 0, 16'h8000, 16'h8000, 0);
    send_frame(16'h0000, 16'h0000, 16'h0000, 1, 16'h0000, 16'hFFFF, 0);
    send_frame(16'h8000, 16'hFFFF, 16'hFFFF, 0, 16'h7FFF, 16'h8000, 0);
    for (int i = 0; i < 8; i++)
      send_frame(16'hFFFF, 16'(i * 16'h1234), 16'h4000, 0, 16'h0000, 16'h0001, 0);
    drain();
    write_cfg(REG_MODE, 3'd0);
    write_cfg(REG_MOD_INDEX, 16'h8000);
    write_cfg(REG_BASE_INC, 24'hFFFFFF);
    send_random(6, 0);
    drain();

    // Random phases across several settings
    for (int ph = 0; ph < 8; ph++) begin
      random_config();
      if (ph == 3) begin
        rx_hold = 1;
        send_random(30, 1);
      end
      rx_calm = (ph == 5);
      send_random(80, 0);
      rx_calm = 0;
      drain();
    end

    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("fm_operator_pair_voice_top_tb: clean");
    else
      $display("fm_operator_pair_voice_top_tb: errors");
    $finish;
  end
endmodule

/* sim.f */
sv/fmop_pkg.sv
sv/fmop_ctrl.sv
sv/fmop_dp.sv
sv/fm_operator_pair_voice_top.sv
sv/fmop_checker.sv
tb/sv/fm_operator_pair_voice_top_tb.sv
